// ===== rtl/jsv_pkg.sv =====
`default_nettype none

package jsv_pkg;

  // Scan phases of the recognizer. Codes above PH_ERR are never reached.
  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_LIT    = 4'd1,
    PH_SIGN   = 4'd2,
    PH_ZERO   = 4'd3,
    PH_INT    = 4'd4,
    PH_DOT    = 4'd5,
    PH_FRAC   = 4'd6,
    PH_EXP    = 4'd7,
    PH_EXPSGN = 4'd8,
    PH_EXPDIG = 4'd9,
    PH_TRAIL  = 4'd10,
    PH_ERR    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXPECT    = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOTSINGLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NULL   = 2'd0,
    KIND_FALSE  = 2'd1,
    KIND_TRUE   = 2'd2,
    KIND_NUMBER = 2'd3
  } kind_t;

  typedef struct packed {
    status_t status;
    kind_t   kind;
  } scan_result_t;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_T     = 8'h74;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_LOW_E) || (c == CH_UP_E);
  endfunction

  // Length of each literal; the unused choice spells null.
  function automatic logic [2:0] lit_len(input logic [1:0] choice);
    logic [2:0] len;
    case (choice)
      2'd1:    len = 3'd5;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  // Character of a literal at a position; zero past its end.
  function automatic logic [7:0] lit_char(input logic [1:0] choice, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (choice)
      2'd1: begin
        case (pos)
          3'd0:    ch = 8'h66;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h73;
          3'd4:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    ch = 8'h74;
          3'd1:    ch = 8'h72;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = 8'h6E;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsv_scan.sv =====
`default_nettype none

// Recognizer state machine. One character is consumed in each cycle that
// step is high; on the end character the result is presented and the state
// returns to its reset values.
module jsv_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            text_byte,
  output jsv_pkg::scan_result_t      result
);

  jsv_pkg::phase_t  phase, phase_next;
  logic [2:0]       lit_pos, lit_pos_next;
  logic [1:0]       lit_choice, lit_choice_next;
  jsv_pkg::status_t err, err_next;
  jsv_pkg::kind_t   kind, kind_next;

  logic             c_ws;
  logic             c_digit;
  logic             c_end;
  logic [2:0]       pos_inc;

  assign c_ws    = jsv_pkg::is_ws(text_byte);
  assign c_digit = jsv_pkg::is_digit(text_byte);
  assign c_end   = (text_byte == jsv_pkg::CH_END);
  assign pos_inc = lit_pos + 3'd1;

  // Next state.
  always_comb begin
    phase_next      = phase;
    lit_pos_next    = lit_pos;
    lit_choice_next = lit_choice;
    err_next        = err;
    kind_next       = kind;
    case (phase)
      jsv_pkg::PH_LEAD: begin
        if (c_ws) begin
          phase_next = jsv_pkg::PH_LEAD;
        end else if (c_end) begin
          err_next   = jsv_pkg::ST_EXPECT;
          phase_next = jsv_pkg::PH_ERR;
        end else if (text_byte == jsv_pkg::CH_N || text_byte == jsv_pkg::CH_F ||
                     text_byte == jsv_pkg::CH_T) begin
          lit_choice_next = (text_byte == jsv_pkg::CH_N) ? 2'd0 :
                            ((text_byte == jsv_pkg::CH_F) ? 2'd1 : 2'd2);
          lit_pos_next    = 3'd1;
          phase_next      = jsv_pkg::PH_LIT;
        end else if (text_byte == jsv_pkg::CH_MINUS) begin
          phase_next = jsv_pkg::PH_SIGN;
        end else if (text_byte == jsv_pkg::CH_ZERO) begin
          phase_next = jsv_pkg::PH_ZERO;
        end else if (c_digit) begin
          phase_next = jsv_pkg::PH_INT;
        end else begin
          err_next   = jsv_pkg::ST_INVALID;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      jsv_pkg::PH_LIT: begin
        if (lit_pos < jsv_pkg::lit_len(lit_choice) &&
            text_byte == jsv_pkg::lit_char(lit_choice, lit_pos)) begin
          lit_pos_next = pos_inc;
          if (pos_inc >= jsv_pkg::lit_len(lit_choice)) begin
            kind_next  = jsv_pkg::kind_t'(lit_choice);
            phase_next = jsv_pkg::PH_TRAIL;
          end
        end else begin
          err_next   = jsv_pkg::ST_INVALID;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      jsv_pkg::PH_SIGN: begin
        if (text_byte == jsv_pkg::CH_ZERO) begin
          phase_next = jsv_pkg::PH_ZERO;
        end else if (c_digit) begin
          phase_next = jsv_pkg::PH_INT;
        end else begin
          err_next   = jsv_pkg::ST_INVALID;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC: begin
        if ((phase != jsv_pkg::PH_ZERO) && c_digit) begin
          phase_next = phase;
        end else if ((phase != jsv_pkg::PH_FRAC) && text_byte == jsv_pkg::CH_DOT) begin
          phase_next = jsv_pkg::PH_DOT;
        end else if (jsv_pkg::is_exp(text_byte)) begin
          phase_next = jsv_pkg::PH_EXP;
        end else begin
          kind_next = jsv_pkg::KIND_NUMBER;
          if (c_ws || c_end) begin
            phase_next = jsv_pkg::PH_TRAIL;
          end else begin
            err_next   = jsv_pkg::ST_NOTSINGLE;
            phase_next = jsv_pkg::PH_ERR;
          end
        end
      end
      jsv_pkg::PH_DOT, jsv_pkg::PH_EXPSGN: begin
        if (c_digit) begin
          phase_next = (phase == jsv_pkg::PH_DOT) ? jsv_pkg::PH_FRAC : jsv_pkg::PH_EXPDIG;
        end else begin
          err_next   = jsv_pkg::ST_INVALID;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      jsv_pkg::PH_EXP: begin
        if (text_byte == jsv_pkg::CH_PLUS || text_byte == jsv_pkg::CH_MINUS) begin
          phase_next = jsv_pkg::PH_EXPSGN;
        end else if (c_digit) begin
          phase_next = jsv_pkg::PH_EXPDIG;
        end else begin
          err_next   = jsv_pkg::ST_INVALID;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      jsv_pkg::PH_EXPDIG: begin
        if (!c_digit) begin
          kind_next = jsv_pkg::KIND_NUMBER;
          if (c_ws || c_end) begin
            phase_next = jsv_pkg::PH_TRAIL;
          end else begin
            err_next   = jsv_pkg::ST_NOTSINGLE;
            phase_next = jsv_pkg::PH_ERR;
          end
        end
      end
      jsv_pkg::PH_TRAIL: begin
        if (!(c_ws || c_end)) begin
          err_next   = jsv_pkg::ST_NOTSINGLE;
          phase_next = jsv_pkg::PH_ERR;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Result seen at the end character: the first error, or the kind found.
  always_comb begin
    result.status = err_next;
    if (err_next != jsv_pkg::ST_OK) begin
      result.kind = jsv_pkg::KIND_NULL;
    end else begin
      result.kind = kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsv_pkg::PH_LEAD;
      lit_pos    <= 3'd0;
      lit_choice <= 2'd0;
      err        <= jsv_pkg::ST_OK;
      kind       <= jsv_pkg::KIND_NULL;
    end else if (step) begin
      if (c_end) begin
        phase      <= jsv_pkg::PH_LEAD;
        lit_pos    <= 3'd0;
        lit_choice <= 2'd0;
        err        <= jsv_pkg::ST_OK;
        kind       <= jsv_pkg::KIND_NULL;
      end else begin
        phase      <= phase_next;
        lit_pos    <= lit_pos_next;
        lit_choice <= lit_choice_next;
        err        <= err_next;
        kind       <= kind_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_scalar_token_validator_unit.sv =====
// JSON scalar recognizer.
// Text arrives on the slave stream one character per transfer; a zero
// character ends the text. The block checks that the text holds exactly one
// JSON scalar (null, false, true or a number) with optional whitespace around
// it, and on the zero character sends one result transfer on the master
// stream carrying a status and the kind of value. Nonzero characters produce
// no result. After a result the recognizer is ready for the next text.
// Each accepted character is held in an input register; a nonzero one is
// consumed by the state machine in the following cycle, so one character per
// cycle is taken unless a zero character waits. A result is loaded into the
// output register at the clock edge that consumes its zero character, and it
// sits there until it is taken.
// When the receiver stalls, nonzero characters keep flowing; a zero character
// waits in the input register until the output register is free, and while
// it waits the slave side takes no characters.
// Synchronous reset empties both registers and returns the recognizer to the
// leading whitespace phase with no error latched.
`default_nettype none

module json_scalar_token_validator_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [1:0] parse_status, [3:2] value_kind, [7:4] zero
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  step;
  logic                  in_end;
  jsv_pkg::scan_result_t result;

  assign in_end   = (in_byte == jsv_pkg::CH_END);
  // A nonzero character always advances; an end character needs room for its result.
  assign step     = in_valid && (!in_end || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  jsv_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (in_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_end) begin
      m_tdata <= {4'b0000, result.kind, result.status};
    end
  end

  // An error result never carries a value kind.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == jsv_pkg::ST_OK || m_tdata[3:2] == jsv_pkg::KIND_NULL))
    else $error("error result with nonzero value kind");

  // Consuming an end character always loads a result.
  assert property (@(posedge clk) disable iff (rst)
    (step && in_end) |=> m_tvalid)
    else $error("end character consumed without a result");

  // A nonzero character never creates a result.
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !(step && in_end)) |=> !m_tvalid)
    else $error("result produced without an end character");

  // The input register never drops a character it has not consumed.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_byte)))
    else $error("pending character lost");

endmodule

`default_nettype wire

// ===== tb/sv/tb_json_scalar_token_validator_unit.sv =====
`timescale 1ns / 100ps

// Texts are sent one character per transfer on the slave stream. Every text
// ends with a zero character, and random noise may hold further zero
// characters, each of which closes a text of its own and yields one result
// transfer. A model of the recognizer kept in this module predicts each result
// as the characters are accepted. The checker compares each result transfer
// against the oldest prediction.
module tb_json_scalar_token_validator_unit;

  // Cycles with no transfer on either side before the run is declared hung.
  // The longest legitimate quiet stretch is the long receiver hold-off below.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [1:0] parse_status, [3:2] value_kind, [7:4] zero

  json_scalar_token_validator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Our own copy of the recognizer state.
  jsv_pkg::phase_t  scan_ph;
  logic [2:0]       word_pos;
  logic [1:0]       word_sel;
  jsv_pkg::status_t first_error;
  jsv_pkg::kind_t   seen_kind;

  // Verdicts predicted for texts whose end character has been accepted.
  jsv_pkg::scan_result_t verdict_q[$];

  // Text being assembled before it is sent.
  logic [7:0] text_buf[$];

  int src_idle   = 0;   // percent of cycles the sender sits idle
  int sink_stall = 0;   // percent of cycles the receiver stalls
  int hold_len   = 0;   // request for a long receiver hold-off
  int hold_left  = 0;
  int mismatches = 0;
  int chars_sent = 0;

  function automatic string literal_word(input logic [1:0] sel);
    case (sel)
      2'd1:    return "false";
      2'd2:    return "true";
      default: return "null";
    endcase
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= jsv_pkg::CH_ZERO && c <= jsv_pkg::CH_NINE;
  endfunction

  task automatic clear_scan();
    scan_ph     = jsv_pkg::PH_LEAD;
    word_pos    = 3'd0;
    word_sel    = 2'd0;
    first_error = jsv_pkg::ST_OK;
    seen_kind   = jsv_pkg::KIND_NULL;
  endtask

  task automatic latch_error(input jsv_pkg::status_t code);
    first_error = code;
    scan_ph     = jsv_pkg::PH_ERR;
  endtask

  // A complete value may be followed only by whitespace or the end character.
  task automatic close_value(input logic [7:0] c);
    if (blank_char(c) || c == jsv_pkg::CH_END) scan_ph = jsv_pkg::PH_TRAIL;
    else latch_error(jsv_pkg::ST_NOTSINGLE);
  endtask

  task automatic close_number(input logic [7:0] c);
    seen_kind = jsv_pkg::KIND_NUMBER;
    close_value(c);
  endtask

  // Advances the recognizer by one accepted character and, on the end
  // character, queues the verdict for the text.
  task automatic judge_char(input logic [7:0] c);
    string w;
    case (scan_ph)
      jsv_pkg::PH_LEAD: begin
        if (blank_char(c)) begin
        end else if (c == jsv_pkg::CH_END) begin
          latch_error(jsv_pkg::ST_EXPECT);
        end else if (c == jsv_pkg::CH_N || c == jsv_pkg::CH_F || c == jsv_pkg::CH_T) begin
          word_sel = (c == jsv_pkg::CH_N) ? 2'd0 : ((c == jsv_pkg::CH_F) ? 2'd1 : 2'd2);
          word_pos = 3'd1;
          scan_ph  = jsv_pkg::PH_LIT;
        end else if (c == jsv_pkg::CH_MINUS) begin
          scan_ph = jsv_pkg::PH_SIGN;
        end else if (c == jsv_pkg::CH_ZERO) begin
          scan_ph = jsv_pkg::PH_ZERO;
        end else if (digit_char(c)) begin
          scan_ph = jsv_pkg::PH_INT;
        end else begin
          latch_error(jsv_pkg::ST_INVALID);
        end
      end
      jsv_pkg::PH_LIT: begin
        w = literal_word(word_sel);
        if (word_pos < w.len() && c == w[word_pos]) begin
          word_pos = word_pos + 3'd1;
          if (word_pos >= w.len()) begin
            seen_kind = jsv_pkg::kind_t'(word_sel);
            scan_ph   = jsv_pkg::PH_TRAIL;
          end
        end else begin
          latch_error(jsv_pkg::ST_INVALID);
        end
      end
      jsv_pkg::PH_SIGN: begin
        if (c == jsv_pkg::CH_ZERO) scan_ph = jsv_pkg::PH_ZERO;
        else if (digit_char(c)) scan_ph = jsv_pkg::PH_INT;
        else latch_error(jsv_pkg::ST_INVALID);
      end
      jsv_pkg::PH_ZERO, jsv_pkg::PH_INT: begin
        if (scan_ph == jsv_pkg::PH_INT && digit_char(c)) begin
        end else if (c == jsv_pkg::CH_DOT) begin
          scan_ph = jsv_pkg::PH_DOT;
        end else if (c == jsv_pkg::CH_LOW_E || c == jsv_pkg::CH_UP_E) begin
          scan_ph = jsv_pkg::PH_EXP;
        end else begin
          close_number(c);
        end
      end
      jsv_pkg::PH_DOT: begin
        if (digit_char(c)) scan_ph = jsv_pkg::PH_FRAC;
        else latch_error(jsv_pkg::ST_INVALID);
      end
      jsv_pkg::PH_FRAC: begin
        if (digit_char(c)) begin
        end else if (c == jsv_pkg::CH_LOW_E || c == jsv_pkg::CH_UP_E) begin
          scan_ph = jsv_pkg::PH_EXP;
        end else begin
          close_number(c);
        end
      end
      jsv_pkg::PH_EXP: begin
        if (c == jsv_pkg::CH_PLUS || c == jsv_pkg::CH_MINUS) scan_ph = jsv_pkg::PH_EXPSGN;
        else if (digit_char(c)) scan_ph = jsv_pkg::PH_EXPDIG;
        else latch_error(jsv_pkg::ST_INVALID);
      end
      jsv_pkg::PH_EXPSGN: begin
        if (digit_char(c)) scan_ph = jsv_pkg::PH_EXPDIG;
        else latch_error(jsv_pkg::ST_INVALID);
      end
      jsv_pkg::PH_EXPDIG: begin
        if (!digit_char(c)) close_number(c);
      end
      jsv_pkg::PH_TRAIL: begin
        close_value(c);
      end
      default: begin
      end
    endcase

    if (c == jsv_pkg::CH_END) begin
      if (first_error != jsv_pkg::ST_OK) begin
        verdict_q.push_back('{status: first_error, kind: jsv_pkg::KIND_NULL});
      end else begin
        verdict_q.push_back('{status: jsv_pkg::ST_OK, kind: seen_kind});
      end
      clear_scan();
    end
  endtask

  task automatic log_error(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // Result checker. Values read right after the edge are the ones the edge
  // sampled, since the block and the drivers update through nonblocking
  // assignments.
  always @(posedge clk) begin : result_check
    jsv_pkg::scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        log_error($sformatf("result 0x%02h with no text pending", m_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[1:0] != want.status || m_tdata[3:2] != want.kind || m_tdata[7:4] != 4'd0)
          log_error($sformatf("expected status %0d kind %0d, got status %0d kind %0d pad %0h",
                              want.status, want.kind, m_tdata[1:0], m_tdata[3:2],
                              m_tdata[7:4]));
      end
    end
  end

  // Receiver. A hold-off request keeps tready low for a fixed count of
  // cycles; otherwise it stalls at random at the current rate.
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // Watchdog on cycles in which neither stream moves a transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_json_scalar_token_validator_unit: errors");
    $finish;
  end

  // Offers one character and returns at the edge that accepts it. tvalid is
  // left high so that a following call can keep it asserted without a gap.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    judge_char(c);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i]);
    send_char(jsv_pkg::CH_END);
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Drops tvalid and waits until every predicted result has arrived.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range(jsv_pkg::CH_NINE, jsv_pkg::CH_ZERO));
  endfunction

  // Half the time a character from a pool that is mostly grammar characters, else any nonzero.
  function automatic logic [7:0] pick_stray();
    string pool;
    pool = "0123456789+-.eEnulfastr x\t";
    if ($urandom_range(1) == 0) return pool[$urandom_range(pool.len() - 1)];
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic add_blanks();
    repeat ($urandom_range(2)) text_buf.push_back(pick_blank());
  endtask

  task automatic add_literal();
    string w;
    w = literal_word(2'($urandom_range(2)));
    foreach (w[i]) text_buf.push_back(w[i]);
  endtask

  task automatic add_number();
    if ($urandom_range(1) == 0) text_buf.push_back(jsv_pkg::CH_MINUS);
    if ($urandom_range(3) == 0) begin
      text_buf.push_back(jsv_pkg::CH_ZERO);
    end else begin
      text_buf.push_back(8'($urandom_range(jsv_pkg::CH_NINE, jsv_pkg::CH_ZERO + 8'd1)));
      repeat ($urandom_range(4)) text_buf.push_back(pick_digit());
    end
    if ($urandom_range(1) == 0) begin
      text_buf.push_back(jsv_pkg::CH_DOT);
      repeat ($urandom_range(3, 1)) text_buf.push_back(pick_digit());
    end
    if ($urandom_range(1) == 0) begin
      text_buf.push_back($urandom_range(1) ? jsv_pkg::CH_LOW_E : jsv_pkg::CH_UP_E);
      case ($urandom_range(2))
        0:       text_buf.push_back(jsv_pkg::CH_PLUS);
        1:       text_buf.push_back(jsv_pkg::CH_MINUS);
        default: begin
        end
      endcase
      repeat ($urandom_range(3, 1)) text_buf.push_back(pick_digit());
    end
  endtask

  // Mostly well-formed scalars with random content; the rest is noise,
  // whitespace-only texts and damaged scalars.
  task automatic make_text();
    int r;
    int pos;
    r = $urandom_range(99);
    text_buf.delete();
    if (r < 10) begin
      repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255)));
    end else if (r < 14) begin
      repeat ($urandom_range(3)) text_buf.push_back(pick_blank());
    end else begin
      add_blanks();
      if ($urandom_range(2) == 0) add_literal();
      else add_number();
      add_blanks();
      if (r >= 76) begin
        pos = $urandom_range(text_buf.size());
        case ($urandom_range(3))
          0: text_buf.insert(pos, pick_stray());
          1: text_buf[$urandom_range(text_buf.size() - 1)] = pick_stray();
          2: while (text_buf.size() > pos) void'(text_buf.pop_back());
          default: text_buf.push_back(pick_stray());
        endcase
      end
    end
  endtask

  task automatic test_literals();
    send_str("null");
    send_str("false");
    send_str("\ttrue\r\n");
  endtask

  task automatic test_numbers();
    send_str(" -0.5E-7");
    send_str("19e+3");
  endtask

  task automatic test_special_cases();
    // Empty text, with and without whitespace.
    send_str("");
    send_str(" ");
    // Truncated literal.
    send_str("fal");
    // A number followed by a byte that cannot extend it.
    send_str("0123");
    // A fraction with no digits.
    send_str("1.");
    // All bits set, then an error followed by more text that must be ignored.
    text_buf.push_back(8'hFF);
    send_text();
    send_str("n+1");
    wait_drain();
  endtask

  task automatic test_random_texts(input int src, input int sink, input int count);
    int stop_at;
    src_idle   = src;
    sink_stall = sink;
    stop_at    = chars_sent + count;
    while (chars_sent < stop_at) begin
      make_text();
      send_text();
    end
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while texts keep coming, so
  // the output register fills and the slave side has to stop.
  task automatic test_backpressure();
    src_idle   = 0;
    sink_stall = 0;
    hold_len   = HOLD_CYCLES;
    repeat (20) begin
      make_text();
      send_text();
    end
    wait_drain();
  endtask

  initial begin
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_literals();
    test_numbers();
    test_special_cases();

    test_random_texts(0, 0, 300);
    test_random_texts(53, 0, 300);
    test_random_texts(0, 53, 300);
    test_random_texts(28, 28, 300);

    test_backpressure();

    if (verdict_q.size() != 0) log_error("results still pending at the end");
    if (mismatches == 0) begin
      $display("tb_json_scalar_token_validator_unit: clean");
    end else begin
      $display("tb_json_scalar_token_validator_unit: errors");
    end
    $finish;
  end

endmodule
